[rtl/bkt_pkg.sv]
// ----------------------------------------------------------------------------
// bkt_pkg
// Shared constants, command and status codes, and the control group that
// steers the ticket scan of the bakery ticket arbiter.
// ----------------------------------------------------------------------------
package bkt_pkg;

    // Default sizing of the arbiter
    localparam int REQUESTERS_DEF  = 10;
    localparam int TICKET_BITS_DEF = 8;

    // Fixed widths of the channel fields
    localparam int REQ_FIELD_W    = 4;
    localparam int TICKET_FIELD_W = 8;

    // Command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;       // start of a new item: drop old accumulators
        logic sample_vld;  // a ticket read from the store is on the bus
        logic who_vld;     // the item's requester index is in range
    } scan_ctrl_t;

endpackage

[rtl/bkt_if.sv]
// ----------------------------------------------------------------------------
// bkt_cmd_if / bkt_rsp_if
// Valid/ready channels of the arbiter: the command channel carries one
// request or release, the response channel one lock report.
// ----------------------------------------------------------------------------
interface bkt_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] requester;

    modport source (output valid, output command, output requester, input ready);
    modport sink   (input valid, input command, input requester, output ready);
endinterface

interface bkt_rsp_if;
    logic       valid;
    logic       ready;
    logic       holder_valid;
    logic [3:0] holder;
    logic [7:0] ticket_given;
    logic       status;

    modport source (output valid, output holder_valid, output holder,
                    output ticket_given, output status, input ready);
    modport sink   (input valid, input holder_valid, input holder,
                    input ticket_given, input status, output ready);
endinterface

[rtl/bakery_ticket_arbiter_unit.sv]
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter_unit
// Ticket-based mutual-exclusion arbiter in the manner of the bakery scheme.
//
// cmd_chan takes one item: a request (new ticket one above the largest held)
// or a release (clear the requester's ticket). rsp_chan returns exactly one
// item per command: the lock holder (smallest nonzero ticket, ties to the
// lower index), the ticket given and the overflow status.
// Each item walks the ticket store once through its single read port, one
// entry per cycle, then writes the updated ticket back. The entries are read
// one by one, a drain state folds the last entry read into the accumulators
// and a finish state resolves the item and loads the response register.
// A new item is taken only when the block is back in idle after the finish
// state, so it is never taken before the last one is through.
// The response sits in an output register: while the receiver stalls the
// next item is still taken and scanned, and waits in its final cycle until
// the register frees up. Reset clears all tickets at once through per-entry
// valid bits, so the block accepts items right after reset.
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter_unit #(
    parameter int REQUESTERS  = bkt_pkg::REQUESTERS_DEF,
    parameter int TICKET_BITS = bkt_pkg::TICKET_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bkt_cmd_if.sink       cmd_chan,
    bkt_rsp_if.source     rsp_chan
);
    import bkt_pkg::*;

    localparam int IW = $clog2(REQUESTERS);
    localparam logic [IW-1:0] LAST_IDX = IW'(REQUESTERS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

    state_t                 state_reg;
    logic [IW-1:0]          scan_idx_reg;
    logic                   samp_vld_reg;
    logic [IW-1:0]          samp_idx_reg;
    logic                   cmd_reg;
    logic [IW-1:0]          who_reg;
    logic                   in_range_reg;

    logic                   out_valid_reg;
    logic                   out_holder_valid_reg;
    logic [3:0]             out_holder_reg;
    logic [7:0]             out_ticket_reg;
    logic                   out_status_reg;

    logic                   accept;
    logic                   go;
    logic                   in_range;
    scan_ctrl_t             scan_ctrl;
    logic [TICKET_BITS-1:0] rd_ticket;
    logic [TICKET_BITS-1:0] peak_ticket;
    logic                   min_found;
    logic [TICKET_BITS-1:0] min_ticket;
    logic [IW-1:0]          min_idx;
    logic [TICKET_BITS-1:0] own_ticket;

    logic                   is_request;
    logic                   refused;
    logic                   granted;
    logic [TICKET_BITS-1:0] next_ticket;
    logic [TICKET_BITS-1:0] cand_ticket;
    logic                   own_wins;
    logic                   holder_valid_next;
    logic [IW-1:0]          holder_next;
    logic                   wr_en;
    logic [TICKET_BITS-1:0] wr_data;

    // Take a command only between items
    assign cmd_chan.ready = (state_reg == ST_IDLE);
    assign accept         = cmd_chan.valid && cmd_chan.ready;
    assign in_range       = (32'(cmd_chan.requester) < REQUESTERS);

    // Finish an item once the output register is free
    assign go = (state_reg == ST_FINISH) && (!out_valid_reg || rsp_chan.ready);

    // Ticket store
    bkt_ticket_ram #(
        .DEPTH (REQUESTERS),
        .WIDTH (TICKET_BITS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_ticket),
        .wr_en   (wr_en),
        .wr_addr (who_reg),
        .wr_data (wr_data)
    );

    // Scan accumulators
    assign scan_ctrl.clear      = accept;
    assign scan_ctrl.sample_vld = samp_vld_reg;
    assign scan_ctrl.who_vld    = in_range_reg;

    bkt_scan #(
        .REQUESTERS  (REQUESTERS),
        .TICKET_BITS (TICKET_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (scan_ctrl),
        .who           (who_reg),
        .sample_idx    (samp_idx_reg),
        .sample_ticket (rd_ticket),
        .peak_ticket   (peak_ticket),
        .min_found     (min_found),
        .min_ticket    (min_ticket),
        .min_idx       (min_idx),
        .own_ticket    (own_ticket)
    );

    // Resolve the update and the new holder from the scan results
    always_comb
    begin
        is_request  = (cmd_reg == CMD_REQUEST);
        refused     = in_range_reg && is_request && (peak_ticket == '1);
        granted     = in_range_reg && is_request && (peak_ticket != '1);
        next_ticket = peak_ticket + 1'b1;
        wr_en       = go && in_range_reg && !refused;
        wr_data     = is_request ? next_ticket : '0;

        // Own requester's ticket after this item
        if (!in_range_reg || !is_request)
        begin
            cand_ticket = '0;
        end
        else if (granted)
        begin
            cand_ticket = next_ticket;
        end
        else
        begin
            cand_ticket = own_ticket;
        end

        own_wins = (cand_ticket != '0) &&
                   (!min_found || (cand_ticket < min_ticket) ||
                    ((cand_ticket == min_ticket) && (who_reg < min_idx)));
        holder_valid_next = own_wins || min_found;
        holder_next       = own_wins ? who_reg : (min_found ? min_idx : '0);
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            scan_idx_reg         <= '0;
            samp_vld_reg         <= 1'b0;
            samp_idx_reg         <= '0;
            cmd_reg              <= CMD_REQUEST;
            who_reg              <= '0;
            in_range_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            out_holder_valid_reg <= 1'b0;
            out_holder_reg       <= '0;
            out_ticket_reg       <= '0;
            out_status_reg       <= STATUS_OK;
        end
        else
        begin
            samp_vld_reg <= (state_reg == ST_SCAN);
            samp_idx_reg <= scan_idx_reg;

            // Drop the response once taken, unless a new one loads now
            if (rsp_chan.ready && !go)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg      <= cmd_chan.command;
                        who_reg      <= IW'(cmd_chan.requester);
                        in_range_reg <= in_range;
                        scan_idx_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (go)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_holder_valid_reg <= holder_valid_next;
                        out_holder_reg       <= 4'(holder_next);
                        out_ticket_reg       <= granted ? 8'(next_ticket) : 8'd0;
                        out_status_reg       <= refused ? STATUS_REFUSED : STATUS_OK;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_chan.valid        = out_valid_reg;
    assign rsp_chan.holder_valid = out_holder_valid_reg;
    assign rsp_chan.holder       = out_holder_reg;
    assign rsp_chan.ticket_given = out_ticket_reg;
    assign rsp_chan.status       = out_status_reg;

    // Checks
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("accepted item did not start a scan at entry zero");

    a_write_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_FINISH) && (!out_valid_reg || rsp_chan.ready))
        else $error("ticket write outside of a completing item");

    a_holder_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_chan.valid && rsp_chan.holder_valid) |-> (32'(rsp_chan.holder) < REQUESTERS))
        else $error("reported holder beyond the requester count");

    a_refused_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_chan.valid && (rsp_chan.status == STATUS_REFUSED)) |-> (rsp_chan.ticket_given == '0))
        else $error("refused request reports a ticket");

endmodule

[rtl/bkt_ticket_ram.sv]
// ----------------------------------------------------------------------------
// bkt_ticket_ram
// Ticket store: one synchronous (registered) read port and one write
// port. A valid bit per entry, cleared at reset, makes an entry that
// was never written read as zero.
// ----------------------------------------------------------------------------
module bkt_ticket_ram #(
    parameter int DEPTH = 10,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    // Write the array; reads are registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track which entries hold a written value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as an idle ticket
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[rtl/bkt_scan.sv]
// ----------------------------------------------------------------------------
// bkt_scan
// Accumulates one pass over the ticket store: the largest ticket held, the
// smallest nonzero ticket of all other requesters (ties to the lower index)
// and the current ticket of the item's own requester.
// ----------------------------------------------------------------------------
module bkt_scan #(
    parameter int REQUESTERS  = 10,
    parameter int TICKET_BITS = 8,
    localparam int IW         = $clog2(REQUESTERS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bkt_pkg::scan_ctrl_t    ctrl,
    input  logic [IW-1:0]          who,
    input  logic [IW-1:0]          sample_idx,
    input  logic [TICKET_BITS-1:0] sample_ticket,
    output logic [TICKET_BITS-1:0] peak_ticket,
    output logic                   min_found,
    output logic [TICKET_BITS-1:0] min_ticket,
    output logic [IW-1:0]          min_idx,
    output logic [TICKET_BITS-1:0] own_ticket
);
    import bkt_pkg::*;

    logic [TICKET_BITS-1:0] max_reg;
    logic                   found_reg;
    logic [TICKET_BITS-1:0] min_reg;
    logic [IW-1:0]          idx_reg;
    logic [TICKET_BITS-1:0] own_reg;
    logic                   is_own;

    assign is_own = ctrl.who_vld && (sample_idx == who);

    // Fold one sample per cycle into the accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            found_reg <= 1'b0;
            min_reg   <= '0;
            idx_reg   <= '0;
            own_reg   <= '0;
        end
        else if (ctrl.clear)
        begin
            max_reg   <= '0;
            found_reg <= 1'b0;
            own_reg   <= '0;
        end
        else if (ctrl.sample_vld)
        begin
            if (sample_ticket > max_reg)
            begin
                max_reg <= sample_ticket;
            end
            if (is_own)
            begin
                own_reg <= sample_ticket;
            end
            else if ((sample_ticket != '0) && (!found_reg || (sample_ticket < min_reg)))
            begin
                found_reg <= 1'b1;
                min_reg   <= sample_ticket;
                idx_reg   <= sample_idx;
            end
        end
    end

    assign peak_ticket = max_reg;
    assign min_found   = found_reg;
    assign min_ticket  = min_reg;
    assign min_idx     = idx_reg;
    assign own_ticket  = own_reg;

endmodule

[tb/sv/bakery_ticket_arbiter_unit_tb.sv]
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter_unit_tb
// Self-checking bench for the bakery ticket arbiter. A shadow ticket table
// predicts the lock report of every accepted command. Each report from the
// response channel is checked field by field against the oldest prediction.
// Traffic runs in this order: directed corner cases, a climb to ticket
// overflow, a long receiver stall, sender pauses, random lock sessions with
// idle bursts on both channels, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter_unit_tb;
    import bkt_pkg::*;

    localparam int NUM_REQ             = REQUESTERS_DEF;
    localparam int TKT_W               = TICKET_BITS_DEF;
    localparam int REQ_IDX_MAX         = (1 << REQ_FIELD_W) - 1;
    localparam int CLK_HALF            = 5;
    localparam int RESET_CYCLES        = 7;
    localparam int STALL_LIMIT         = 2000;
    localparam int DRAIN_CYCLES        = 20;
    localparam int MAX_PRINT           = 25;
    localparam int BACKPRESSURE_CYCLES = 150;
    localparam int SWEEP_LEVEL         = 250;

    typedef logic [TKT_W-1:0]       ticket_t;
    typedef logic [REQ_FIELD_W-1:0] req_idx_t;

    typedef struct packed {
        logic                      holder_valid;
        req_idx_t                  holder;
        logic [TICKET_FIELD_W-1:0] ticket_given;
        logic                      status;
    } lock_report_t;

    logic clk;
    logic rst_n;

    bkt_cmd_if cmd_bus ();
    bkt_rsp_if rsp_bus ();

    bakery_ticket_arbiter_unit #(
        .REQUESTERS  (NUM_REQ),
        .TICKET_BITS (TKT_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_chan (cmd_bus),
        .rsp_chan (rsp_bus)
    );

    // Shadow ticket table and the lock reports still owed by the block
    ticket_t      ticket_tbl [NUM_REQ] = '{default: '0};
    lock_report_t pending_reports [$];

    bit snd_idle_en  = 1'b1;
    bit rcv_idle_en  = 1'b1;
    int rcv_hold_len = 0;

    int mismatch_cnt = 0;
    int cmd_cnt      = 0;
    int report_cnt   = 0;
    int refused_cnt  = 0;
    int ignored_cnt  = 0;
    int stall_cnt    = 0;

    // ------------------------------------------------------------------------
    // Ticket table predictor
    // ------------------------------------------------------------------------

    function automatic ticket_t top_ticket();
        ticket_t best;
        best = '0;
        for (int k = 0; k < NUM_REQ; k++)
        begin
            if (ticket_tbl[k] > best)
                best = ticket_tbl[k];
        end
        return best;
    endfunction

    // Smallest nonzero ticket wins, ties to the lower index; -1 when all idle
    function automatic int lowest_holder();
        int pick;
        pick = -1;
        for (int k = 0; k < NUM_REQ; k++)
        begin
            if (ticket_tbl[k] != '0 && (pick < 0 || ticket_tbl[k] < ticket_tbl[pick]))
                pick = k;
        end
        return pick;
    endfunction

    // Apply one command to the table and return the lock report it causes
    function automatic lock_report_t apply_command(logic cmd, req_idx_t who);
        lock_report_t rpt;
        ticket_t      top;
        ticket_t      next_tkt;
        int           h;
        rpt = '0;
        if (who < NUM_REQ)
        begin
            if (cmd == CMD_REQUEST)
            begin
                top = top_ticket();
                if (top == '1)
                    rpt.status = STATUS_REFUSED;
                else
                begin
                    next_tkt         = top + 1'b1;
                    ticket_tbl[who]  = next_tkt;
                    rpt.ticket_given = next_tkt;
                end
            end
            else
                ticket_tbl[who] = '0;
        end
        h = lowest_holder();
        rpt.holder_valid = (h >= 0);
        rpt.holder       = (h >= 0) ? req_idx_t'(h) : '0;
        return rpt;
    endfunction

    // Random requester that holds (or does not hold) a ticket; -1 if none
    function automatic int pick_requester(bit holding);
        int cands [$];
        for (int k = 0; k < NUM_REQ; k++)
        begin
            if ((ticket_tbl[k] != '0) == holding)
                cands.push_back(k);
        end
        if (cands.size() == 0)
            return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog and response side
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // End the run when no item moves on either channel for too long
    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without an item on either channel", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Drive response ready: long hold on request, random stall bursts, else ready
    initial
    begin : rcv_proc
        int n;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rcv_hold_len > 0)
            begin
                n            = rcv_hold_len;
                rcv_hold_len = 0;
                rsp_bus.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else if (rcv_idle_en && $urandom_range(0, 5) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned exp_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINT)
            $display("[%0t] report %0d: %s is %0d, expected %0d",
                     $time, report_cnt, what, got_v, exp_v);
    endtask

    // Check each accepted report, then predict for each accepted command
    always @(posedge clk)
    begin : lock_monitor
        lock_report_t got;
        lock_report_t exp;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got = {rsp_bus.holder_valid, rsp_bus.holder, rsp_bus.ticket_given,
                       rsp_bus.status};
                report_cnt++;
                if (pending_reports.size() == 0)
                    report_mismatch("report with no command pending, holder", got.holder, 0);
                else
                begin
                    exp = pending_reports.pop_front();
                    if (got.holder_valid !== exp.holder_valid)
                        report_mismatch("holder_valid", got.holder_valid, exp.holder_valid);
                    if (got.holder !== exp.holder)
                        report_mismatch("holder", got.holder, exp.holder);
                    if (got.ticket_given !== exp.ticket_given)
                        report_mismatch("ticket_given", got.ticket_given, exp.ticket_given);
                    if (got.status !== exp.status)
                        report_mismatch("status", got.status, exp.status);
                end
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                exp = apply_command(cmd_bus.command, cmd_bus.requester);
                pending_reports.push_back(exp);
                cmd_cnt++;
                if (exp.status == STATUS_REFUSED)
                    refused_cnt++;
                if (cmd_bus.requester >= NUM_REQ)
                    ignored_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side; every task starts and ends at a falling edge
    // ------------------------------------------------------------------------

    // Offer one item, with an optional idle burst first, and hold until taken
    task automatic send_command(logic cmd, int who);
        if (snd_idle_en && $urandom_range(0, 4) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.command   <= cmd;
        cmd_bus.requester <= req_idx_t'(who);
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted report has arrived
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
    endtask

    // Release every ticket holder in random order
    task automatic release_all_holders();
        int who;
        who = pick_requester(1'b1);
        while (who >= 0)
        begin
            send_command(CMD_RELEASE, who);
            who = pick_requester(1'b1);
        end
    endtask

    // One item of a lock session: mostly take-a-ticket and holder-releases,
    // with some out-of-range and arbitrary commands mixed in
    task automatic issue_random_command();
        int r;
        int who;
        r = $urandom_range(0, 99);
        if ((top_ticket() >= SWEEP_LEVEL && $urandom_range(0, 5) == 0) ||
            $urandom_range(0, 149) == 0)
            release_all_holders();
        else if (r < 5)
            send_command(1'($urandom_range(0, 1)), $urandom_range(NUM_REQ, REQ_IDX_MAX));
        else if (r < 12)
            send_command(1'($urandom_range(0, 1)), $urandom_range(0, NUM_REQ - 1));
        else if (r < 55)
        begin
            who = pick_requester(1'b0);
            send_command(CMD_REQUEST, (who >= 0) ? who : $urandom_range(0, NUM_REQ - 1));
        end
        else if (r < 85)
        begin
            who = lowest_holder();
            if (who >= 0)
                send_command(CMD_RELEASE, who);
            else
                send_command(CMD_REQUEST, $urandom_range(0, NUM_REQ - 1));
        end
        else
        begin
            who = pick_requester(1'b1);
            if (who < 0)
                who = $urandom_range(0, NUM_REQ - 1);
            send_command(CMD_RELEASE, who);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // First tickets, holder hand-over, repeated request, idle release,
    // out-of-range requesters and every requester bit
    task automatic test_directed_cases();
        send_command(CMD_REQUEST, 0);
        send_command(CMD_REQUEST, 9);
        send_command(CMD_REQUEST, 5);
        send_command(CMD_RELEASE, 0);
        send_command(CMD_REQUEST, 9);
        send_command(CMD_RELEASE, 5);
        send_command(CMD_RELEASE, 3);
        send_command(CMD_REQUEST, 15);
        send_command(CMD_RELEASE, 12);
        send_command(CMD_REQUEST, 10);
        send_command(CMD_REQUEST, 8);
        send_command(CMD_REQUEST, 1);
        send_command(CMD_REQUEST, 2);
        send_command(CMD_REQUEST, 4);
        send_command(CMD_REQUEST, 6);
        send_command(CMD_REQUEST, 7);
        send_command(CMD_REQUEST, 3);
        release_all_holders();
    endtask

    // Climb to the largest ticket, then hit overflow with and without the
    // top ticket still held
    task automatic test_ticket_overflow();
        int who;
        int top_owner;
        who = 0;
        while (top_ticket() != '1)
        begin
            send_command(CMD_REQUEST, who);
            who = (who + 1) % NUM_REQ;
        end
        top_owner = (who + NUM_REQ - 1) % NUM_REQ;
        send_command(CMD_REQUEST, who);
        send_command(CMD_REQUEST, 14);
        send_command(CMD_RELEASE, who);
        send_command(CMD_REQUEST, who);
        send_command(CMD_RELEASE, top_owner);
        send_command(CMD_REQUEST, who);
        send_command(CMD_REQUEST, top_owner);
        release_all_holders();
    endtask

    // Hold the response side long enough that the block stalls its input
    task automatic test_output_backpressure();
        snd_idle_en  = 1'b0;
        rcv_hold_len = BACKPRESSURE_CYCLES;
        repeat (24) issue_random_command();
        wait_drained();
        snd_idle_en = 1'b1;
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_sender_pause();
        repeat (4)
        begin
            repeat ($urandom_range(5, 15)) issue_random_command();
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        repeat (1150) issue_random_command();
    endtask

    // No idling on either side
    task automatic test_full_rate();
        snd_idle_en = 1'b0;
        rcv_idle_en = 1'b0;
        repeat (150) issue_random_command();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.command   = CMD_REQUEST;
        cmd_bus.requester = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_ticket_overflow();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        test_full_rate();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d commands: %0d refused on ticket overflow, %0d out-of-range",
                 cmd_cnt, refused_cnt, ignored_cnt);
        $display("Checked %0d lock reports, %0d field mismatches", report_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/bkt_pkg.sv
rtl/bkt_if.sv
rtl/bkt_ticket_ram.sv
rtl/bkt_scan.sv
rtl/bakery_ticket_arbiter_unit.sv
tb/sv/bakery_ticket_arbiter_unit_tb.sv
